// File: rtl/mcbd_pkg.sv
package mcbd_pkg;

    localparam int MAX_DIM    = 2048;
    localparam int MAX_LEVELS = 12;

    localparam int DIM_W   = 12;                    // configured size field
    localparam int COORD_W = 11;                    // texel column / row
    localparam int LVL_W   = 4;                     // level number
    localparam int LIDX_W  = $clog2(MAX_LEVELS);    // index into per-level state
    localparam int ADDR_W  = $clog2(MAX_DIM);       // row sum memory address
    localparam int CH_W    = 16;                    // one color channel
    localparam int PIX_W   = 3 * CH_W;              // red, green, blue
    localparam int SUM_W   = 18;                    // one channel of a pair sum
    localparam int ROW_W   = 3 * SUM_W;             // one row sum entry
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    // Size of one level: clamp the register to 1..MAX_DIM, halve per level, floor at 1.
    function automatic logic [DIM_W-1:0] level_dim(input logic [DIM_W-1:0] top,
                                                   input logic [LVL_W-1:0] lvl);
        logic [DIM_W-1:0] c;
        logic [DIM_W-1:0] d;
        c = top;
        if (top == '0) c = DIM_W'(1);
        else if (top > DIM_MAX) c = DIM_MAX;
        d = c >> lvl;
        if (d == '0) d = DIM_W'(1);
        return d;
    endfunction

endpackage

// File: rtl/mcbd_front.sv
module mcbd_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [mcbd_pkg::PIX_W-1:0] s_tdata,
    output logic                      q_valid,
    output logic [mcbd_pkg::PIX_W-1:0] q_data,
    input  logic                      q_pop
);
    import mcbd_pkg::*;

    // Two-entry pixel queue between the input beat and the level sequencer
    logic [PIX_W-1:0] slot_reg [2];
    logic             rd_ptr_reg, wr_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
        if (push) slot_reg[wr_ptr_reg] <= s_tdata;
    end

endmodule

// File: rtl/mcbd_back.sv
module mcbd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mcbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcbd_pkg::DIM_W-1:0]    cfg_data,
    input  logic                          q_valid,
    input  logic [mcbd_pkg::PIX_W-1:0]    q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,
    output logic [mcbd_pkg::LVL_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import mcbd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EMIT, S_CALC} state_t;

    state_t             state_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic [PIX_W-1:0]   cur_reg;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [COORD_W-1:0] col_reg  [MAX_LEVELS];
    logic [COORD_W-1:0] row_reg  [MAX_LEVELS];
    logic [PIX_W-1:0]   held_reg [MAX_LEVELS];
    logic               vert_reg;
    logic [ROW_W-1:0]   rps_mem [MAX_DIM];
    logic [ROW_W-1:0]   rd_q;

    logic               out_v_reg;
    logic [71:0]        out_d_reg;
    logic [LVL_W-1:0]   out_u_reg;
    logic               out_l_reg;

    // Current level geometry
    logic [LIDX_W-1:0]  li;
    logic [DIM_W-1:0]   sw, sh, x, y, x_inc, y_inc, base, idx;
    logic               one_wide, one_high, room, x_in, y_in, idx_ok;
    logic               wr_held, wr_pair, wr_single, rd_mem, made_h, made;
    logic               out_free;
    logic [PIX_W-1:0]   held, res_h, res_c;
    logic [ROW_W-1:0]   pair_sum;

    assign li       = LIDX_W'(lvl_reg);
    assign sw       = level_dim(width_reg, lvl_reg);
    assign sh       = level_dim(height_reg, lvl_reg);
    assign x        = DIM_W'(col_reg[li]);
    assign y        = DIM_W'(row_reg[li]);
    assign held     = held_reg[li];
    assign one_wide = (sw == DIM_W'(1));
    assign one_high = (sh == DIM_W'(1));
    assign room     = (lvl_reg < LVL_W'(MAX_LEVELS - 1)) && !(one_wide && one_high);
    assign x_in     = x < (sw & ~DIM_W'(1));
    assign y_in     = y < (sh & ~DIM_W'(1));
    assign base     = DIM_MAX - (DIM_MAX >> lvl_reg);
    assign idx      = one_wide ? base : base + (x >> 1);
    assign idx_ok   = idx < DIM_MAX;

    // What this level does with the texel now being sent
    always_comb begin
        wr_held   = 1'b0;
        wr_pair   = 1'b0;
        wr_single = 1'b0;
        rd_mem    = 1'b0;
        made_h    = 1'b0;
        if (room) begin
            if (one_wide) begin
                if (y_in && idx_ok) begin
                    if (!y[0]) wr_single = 1'b1;
                    else       rd_mem    = 1'b1;
                end
            end else if (one_high) begin
                if (x_in) begin
                    if (!x[0]) wr_held = 1'b1;
                    else       made_h  = 1'b1;
                end
            end else if (x_in && y_in && idx_ok) begin
                if (!x[0])      wr_held = 1'b1;
                else if (!y[0]) wr_pair = 1'b1;
                else            rd_mem  = 1'b1;
            end
        end
    end
    assign made = rd_mem || made_h;

    // Channel arithmetic: horizontal pair, pair sum, and read-back results
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [CH_W:0]    h2;
            logic [SUM_W:0]   v2;
            logic [SUM_W:0]   q4;
            logic [SUM_W-1:0] ps;
            h2 = {1'b0, held[c*CH_W +: CH_W]} + {1'b0, cur_reg[c*CH_W +: CH_W]}
                 + (CH_W+1)'(1);
            res_h[c*CH_W +: CH_W] = h2[CH_W:1];
            ps = SUM_W'(held[c*CH_W +: CH_W]) + SUM_W'(cur_reg[c*CH_W +: CH_W]);
            pair_sum[c*SUM_W +: SUM_W] = ps;
            v2 = {1'b0, rd_q[c*SUM_W +: SUM_W]} + (SUM_W+1)'(cur_reg[c*CH_W +: CH_W])
                 + (SUM_W+1)'(1);
            q4 = {1'b0, rd_q[c*SUM_W +: SUM_W]} + (SUM_W+1)'(held[c*CH_W +: CH_W])
                 + (SUM_W+1)'(cur_reg[c*CH_W +: CH_W]) + (SUM_W+1)'(2);
            res_c[c*CH_W +: CH_W] = vert_reg ? v2[CH_W:1] : q4[CH_W+1:2];
        end
    end

    assign x_inc    = x + DIM_W'(1);
    assign y_inc    = y + DIM_W'(1);
    assign out_free = !out_v_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // Level sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            out_v_reg  <= 1'b0;
            width_reg  <= DIM_MAX;
            height_reg <= DIM_MAX;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
                held_reg[i] <= '0;
            end
        end else begin
            if (m_tready) out_v_reg <= 1'b0;
            if (cfg_we) begin
                if (cfg_index == CFG_WIDTH)  width_reg  <= cfg_data;
                if (cfg_index == CFG_HEIGHT) height_reg <= cfg_data;
                for (int i = 0; i < MAX_LEVELS; i++) begin
                    col_reg[i]  <= '0;
                    row_reg[i]  <= '0;
                    held_reg[i] <= '0;
                end
            end else begin
                case (state_reg)
                    S_IDLE: begin
                        if (q_valid) begin
                            cur_reg   <= q_data;
                            lvl_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                    S_EMIT: begin
                        if (out_free) begin
                            out_v_reg <= 1'b1;
                            out_u_reg <= lvl_reg;
                            out_l_reg <= !made;
                            out_d_reg <= {2'b00, cur_reg, COORD_W'(y), COORD_W'(x)};
                            if (x_inc >= sw) begin
                                col_reg[li] <= '0;
                                row_reg[li] <= (y_inc >= sh) ? '0 : COORD_W'(y_inc);
                            end else begin
                                col_reg[li] <= COORD_W'(x_inc);
                            end
                            if (wr_held) held_reg[li] <= cur_reg;
                            vert_reg <= one_wide;
                            if (made_h) begin
                                cur_reg   <= res_h;
                                lvl_reg   <= lvl_reg + LVL_W'(1);
                                state_reg <= S_EMIT;
                            end else if (rd_mem) begin
                                state_reg <= S_CALC;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    S_CALC: begin
                        cur_reg   <= res_c;
                        lvl_reg   <= lvl_reg + LVL_W'(1);
                        state_reg <= S_EMIT;
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    // Row sum memory: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free && !cfg_we) begin
            if (wr_pair) rps_mem[idx[ADDR_W-1:0]] <= pair_sum;
            if (wr_single) begin
                rps_mem[idx[ADDR_W-1:0]] <= {2'b00, cur_reg[2*CH_W +: CH_W],
                                             2'b00, cur_reg[CH_W +: CH_W],
                                             2'b00, cur_reg[0 +: CH_W]};
            end
            if (rd_mem) rd_q <= rps_mem[idx[ADDR_W-1:0]];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tuser  = out_u_reg;
    assign m_tlast  = out_l_reg;

endmodule

// File: rtl/mipmap_chain_box_downsampler_top.sv
// Mip chain generator with a 2x2 box filter, or a pair filter on a level one
// texel wide or high. Pixels of the top image enter in raster order; each is
// sent out first as a level 0 texel, and finished texels of every coarser
// level down to 1x1 follow it, each tagged with its level and coordinates,
// tlast marking the final beat caused by one pixel. An input queue feeds a
// level sequencer that handles one pixel at a time: the idle state takes the
// pixel and the emit state sends it once the output register is free; each
// further level is sent by the emit state again, straight after a level one
// texel high or after a calculation state that reads the row sum memory.
// Writing either size register restarts the image.
module mipmap_chain_box_downsampler_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mcbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcbd_pkg::DIM_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // in_red, in_green, in_blue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,   // texel_x, texel_y, out_red,
                                                     // out_green, out_blue, pad
    output logic [mcbd_pkg::LVL_W-1:0]    m_tuser,   // level
    output logic                          m_tlast
);
    import mcbd_pkg::*;

    logic             q_valid, q_pop;
    logic [PIX_W-1:0] q_data;

    mcbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    mcbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: bench/mcbd_texel_checker.sv
module mcbd_texel_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mcbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcbd_pkg::DIM_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [47:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [71:0]                    m_tdata,
    input  logic [mcbd_pkg::LVL_W-1:0]     m_tuser,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             texels_pending
);
    import mcbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LVL_W-1:0]   lvl;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [CH_W-1:0]    r;
        logic [CH_W-1:0]    g;
        logic [CH_W-1:0]    b;
        logic               lst;
    } texel_t;

    texel_t expected_texels[$];

    // predictor state
    logic [DIM_W-1:0]   top_w, top_h;
    logic [SUM_W-1:0]   pair_sum[MAX_DIM][3];
    logic [SUM_W-1:0]   held[MAX_LEVELS][3];
    logic [COORD_W:0]   col[MAX_LEVELS];
    logic [COORD_W:0]   row[MAX_LEVELS];

    function automatic int dim_at(logic [DIM_W-1:0] top, int lvl);
        int c, d;
        c = (top == 0) ? 1 : ((top > MAX_DIM) ? MAX_DIM : int'(top));
        d = c >> lvl;
        return (d == 0) ? 1 : d;
    endfunction

    function automatic void restart_image();
        for (int l = 0; l < MAX_LEVELS; l++) begin
            col[l] = '0;
            row[l] = '0;
            for (int c = 0; c < 3; c++) held[l][c] = '0;
        end
    endfunction

    // queue one texel at level lvl, advance its position
    function automatic void push_texel(int lvl, logic [SUM_W-1:0] v[3],
                                       output int px, output int py);
        texel_t t;
        int x, y;
        x = col[lvl];
        y = row[lvl];
        t.lvl = lvl[LVL_W-1:0];
        t.tx  = x[COORD_W-1:0];
        t.ty  = y[COORD_W-1:0];
        t.r   = v[0][CH_W-1:0];
        t.g   = v[1][CH_W-1:0];
        t.b   = v[2][CH_W-1:0];
        t.lst = 1'b0;
        px = x;
        py = y;
        x++;
        if (x >= dim_at(top_w, lvl)) begin
            x = 0;
            y++;
            if (y >= dim_at(top_h, lvl)) y = 0;
        end
        col[lvl] = (COORD_W+1)'(x);
        row[lvl] = (COORD_W+1)'(y);
        expected_texels.push_back(t);
    endfunction

    function automatic void predict_pixel(logic [47:0] pix);
        logic [SUM_W-1:0] cur[3];
        logic [SUM_W-1:0] res[3];
        int x, y, lvl, sw, sh, dw, dh, base, idx;
        bit made;
        texel_t t;
        for (int c = 0; c < 3; c++) cur[c] = SUM_W'(pix[c*CH_W +: CH_W]);
        push_texel(0, cur, x, y);
        lvl = 0;
        while (lvl < MAX_LEVELS - 1) begin
            sw = dim_at(top_w, lvl);
            sh = dim_at(top_h, lvl);
            dw = sw >> 1;
            dh = sh >> 1;
            base = MAX_DIM - (MAX_DIM >> lvl);
            made = 0;
            if (sw == 1 && sh == 1) break;
            if (sw == 1) begin
                if (y < 2 * dh && base < MAX_DIM) begin
                    if (y % 2 == 0) begin
                        for (int c = 0; c < 3; c++) pair_sum[base][c] = cur[c];
                    end else begin
                        for (int c = 0; c < 3; c++)
                            res[c] = SUM_W'((pair_sum[base][c] + cur[c] + 1) >> 1);
                        made = 1;
                    end
                end
            end else if (sh == 1) begin
                if (x < 2 * dw) begin
                    if (x % 2 == 0) begin
                        for (int c = 0; c < 3; c++) held[lvl][c] = cur[c];
                    end else begin
                        for (int c = 0; c < 3; c++)
                            res[c] = SUM_W'((held[lvl][c] + cur[c] + 1) >> 1);
                        made = 1;
                    end
                end
            end else begin
                idx = base + (x >> 1);
                if (x < 2 * dw && y < 2 * dh && idx < MAX_DIM) begin
                    if (x % 2 == 0) begin
                        for (int c = 0; c < 3; c++) held[lvl][c] = cur[c];
                    end else if (y % 2 == 0) begin
                        for (int c = 0; c < 3; c++)
                            pair_sum[idx][c] = held[lvl][c] + cur[c];
                    end else begin
                        for (int c = 0; c < 3; c++)
                            res[c] = SUM_W'((pair_sum[idx][c] + held[lvl][c]
                                             + cur[c] + 2) >> 2);
                        made = 1;
                    end
                end
            end
            if (!made) break;
            lvl++;
            cur = res;
            push_texel(lvl, cur, x, y);
        end
        t = expected_texels.pop_back();
        t.lst = 1'b1;
        expected_texels.push_back(t);
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin
        texel_t e;
        if (!aresetn) begin
            top_w = DIM_W'(MAX_DIM);
            top_h = DIM_W'(MAX_DIM);
            restart_image();
            expected_texels.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_WIDTH) top_w = cfg_data;
                else top_h = cfg_data;
                restart_image();
            end
            if (s_tvalid && s_tready) predict_pixel(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_texels.size() == 0) begin
                    $error("texel beat with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    e = expected_texels.pop_front();
                    check_field("level", e.lvl, m_tuser);
                    check_field("texel_x", e.tx, m_tdata[10:0]);
                    check_field("texel_y", e.ty, m_tdata[21:11]);
                    check_field("out_red", e.r, m_tdata[37:22]);
                    check_field("out_green", e.g, m_tdata[53:38]);
                    check_field("out_blue", e.b, m_tdata[69:54]);
                    check_field("last", e.lst, m_tlast);
                end
            end
        end
        texels_pending = expected_texels.size();
    end

endmodule

// File: bench/tb_mipmap_chain_box_downsampler_top.sv
module tb_mipmap_chain_box_downsampler_top;
    import mcbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [71:0]          m_tdata;
    logic [LVL_W-1:0]     m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   texels_pending;
    bit                   hold_long = 0;
    int                   idle_cycles = 0;

    always #5 aclk = ~aclk;

    mipmap_chain_box_downsampler_top dut (.*);

    mcbd_texel_checker checker_i (.*);

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // tvalid stays up across back-to-back beats; drain() drops it
    task automatic send_pixel(logic [47:0] pix);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [47:0] rand_pixel();
        logic [15:0] ch[3];
        for (int c = 0; c < 3; c++) begin
            case ($urandom_range(0, 5))
                0: ch[c] = 16'h0000;
                1: ch[c] = 16'hFFFF;
                default: ch[c] = 16'($urandom);
            endcase
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until all texels are out, then let the sequencer settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (texels_pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic run_image(int w, int h, int npix);
        write_reg(CFG_WIDTH, DIM_W'(w));
        write_reg(CFG_HEIGHT, DIM_W'(h));
        for (int i = 0; i < npix; i++) send_pixel(rand_pixel());
        drain();
    endtask

    // receiver: random stalls, and one long hold-off on request
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_long = 0;
            end
            g = gap_len();
            if (g == 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog on cycles with no beat accepted
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_mipmap_chain_box_downsampler_top: FAIL");
            $finish;
        end
    end

    initial begin
        int w, h;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of the channels on a 4x4 image, then odd and thin shapes
        write_reg(CFG_WIDTH, 12'd4);
        write_reg(CFG_HEIGHT, 12'd4);
        for (int i = 0; i < 8; i++) send_pixel(48'hFFFF_FFFF_FFFF);
        for (int i = 0; i < 4; i++) send_pixel(48'h0000_0000_0000);
        for (int i = 0; i < 4; i++) send_pixel(i[0] ? 48'h0001_0001_0001 : '0);
        drain();
        run_image(3, 3, 9);    // odd edges dropped
        run_image(1, 4, 4);    // one wide: vertical pairs
        run_image(4, 1, 4);    // one high: horizontal pairs
        run_image(0, 0, 2);    // zero counts as one
        run_image(4095, 1, 4); // clamps to the maximum width

        // pressure: long receiver hold-off while pixels keep coming
        write_reg(CFG_WIDTH, 12'd8);
        write_reg(CFG_HEIGHT, 12'd8);
        hold_long = 1;
        for (int i = 0; i < 32; i++) send_pixel(rand_pixel());
        drain();

        // random images, mostly small, whole frames plus a wrap
        for (int k = 0; k < 4; k++) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 6);
            run_image(w, h, w * h + $urandom_range(0, w));
        end
        run_image(2048, 2048, 8);
        write_reg(CFG_WIDTH, 12'd2048);
        write_reg(CFG_HEIGHT, 12'd2048);

        drain();
        if (fail_count == 0)
            $display("tb_mipmap_chain_box_downsampler_top: PASS");
        else
            $display("tb_mipmap_chain_box_downsampler_top: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
rtl/mcbd_pkg.sv
rtl/mcbd_front.sv
rtl/mcbd_back.sv
rtl/mipmap_chain_box_downsampler_top.sv
bench/mcbd_texel_checker.sv
bench/tb_mipmap_chain_box_downsampler_top.sv
